// ===== design/lz_pkg.sv =====
package lz_pkg;

   // Fixed-point format of the datapath
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 24;

   // Register and result field widths
   localparam int CSR_BITS  = 32;
   localparam int DT_BITS   = 24;
   localparam int OUT_BITS  = 32;

   // Multiplier operands must hold a word and the unsigned time step
   localparam int OPND_BITS = (WORD_BITS > DT_BITS) ? WORD_BITS : DT_BITS + 1;
   localparam int STEP_BITS = $clog2(OPND_BITS);

   localparam int CSR_INDEX_BITS = 3;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [OPND_BITS-1:0] opnd_type;
   typedef logic [CSR_INDEX_BITS-1:0]   csr_index_type;

   // Register map
   localparam csr_index_type REG_SIGMA   = 3'd0;
   localparam csr_index_type REG_RHO     = 3'd1;
   localparam csr_index_type REG_BETA    = 3'd2;
   localparam csr_index_type REG_DT      = 3'd3;
   localparam csr_index_type REG_START_X = 3'd4;
   localparam csr_index_type REG_START_Y = 3'd5;
   localparam csr_index_type REG_START_Z = 3'd6;

   // Reset values: a = 11, b = 27, c = 2, dt ~ 0.001, start point 5.0
   localparam logic [CSR_BITS-1:0] SIGMA_RESET = 32'd184549376;
   localparam logic [CSR_BITS-1:0] RHO_RESET   = 32'd452984832;
   localparam logic [CSR_BITS-1:0] BETA_RESET  = 32'd33554432;
   localparam logic [DT_BITS-1:0]  DT_RESET    = 24'd16777;
   localparam logic [CSR_BITS-1:0] START_RESET = 32'd83886080;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUB_YX,
      ST_MUL_VX,
      ST_SUB_BZ,
      ST_MUL_XB,
      ST_SUB_VY,
      ST_MUL_XY,
      ST_MUL_CZ,
      ST_SUB_VZ,
      ST_MUL_DX,
      ST_ADD_X,
      ST_MUL_DY,
      ST_ADD_Y,
      ST_MUL_DZ,
      ST_ADD_Z,
      ST_OUT
   } lz_state_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic sat;
   } mul_status_type;

   typedef struct packed {
      logic     sat;
      word_type value;
   } alu_result_type;

   function automatic word_type sat_value(input logic neg);
      word_type r;
      r = neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
      return r;
   endfunction

   // Register value sign-extended from its 32 bits, then taken as a word
   function automatic word_type to_word(input logic [CSR_BITS-1:0] v);
      logic signed [CSR_BITS-1:0] s;
      s = v;
      return word_type'(s);
   endfunction

   function automatic alu_result_type add_sub_sat(input word_type a, input word_type b,
                                                  input logic sub);
      logic signed [WORD_BITS:0] ea;
      logic signed [WORD_BITS:0] eb;
      logic signed [WORD_BITS:0] s;
      alu_result_type r;
      ea      = {a[WORD_BITS-1], a};
      eb      = {b[WORD_BITS-1], b};
      s       = sub ? ea - eb : ea + eb;
      r.sat   = s[WORD_BITS] ^ s[WORD_BITS-1];
      r.value = r.sat ? sat_value(s[WORD_BITS]) : s[WORD_BITS-1:0];
      return r;
   endfunction

endpackage

// ===== design/lz_serial_mul.sv =====
module lz_serial_mul (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  lz_pkg::opnd_type       mcand,
   input  lz_pkg::opnd_type       mplier,
   output lz_pkg::mul_status_type status,
   output lz_pkg::word_type       product
);
   import lz_pkg::*;

   localparam int PROD_BITS = 2 * OPND_BITS;
   localparam int TOP_LSB   = FRAC_BITS + WORD_BITS - 1;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [STEP_BITS-1:0]        step_ff, step_in;
   logic signed [OPND_BITS:0]   hi_ff, hi_in;
   logic [OPND_BITS-1:0]        lo_ff, lo_in;
   opnd_type                    mcand_ff, mcand_in;

   logic                        last_step;
   logic signed [OPND_BITS+1:0] addend;
   logic signed [OPND_BITS+1:0] sum;
   logic [PROD_BITS-1:0]        full;
   logic [PROD_BITS-1:TOP_LSB]  top_bits;
   logic                        fits;

   // Shift-add, one multiplier bit per cycle, LSB first; sign bit has negative weight
   always_comb begin
      last_step = (step_ff == STEP_BITS'(OPND_BITS - 1));
      addend    = '0;
      if (lo_ff[0]) begin
         addend = last_step ? -((OPND_BITS+2)'(mcand_ff)) : (OPND_BITS+2)'(mcand_ff);
      end
      sum = (OPND_BITS+2)'(hi_ff) + addend;

      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         hi_in    = '0;
         lo_in    = mplier;
         mcand_in = mcand;
      end else if (busy_ff) begin
         hi_in   = sum[OPND_BITS+1:1];
         lo_in   = {sum[0], lo_ff[OPND_BITS-1:1]};
         step_in = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
   end

   // Truncate by FRAC_BITS, saturate to a word
   always_comb begin
      full     = {hi_ff[OPND_BITS-1:0], lo_ff};
      top_bits = full[PROD_BITS-1:TOP_LSB];
      fits     = (&top_bits) || !(|top_bits);
      product  = fits ? full[TOP_LSB:FRAC_BITS] : sat_value(full[PROD_BITS-1]);
      status   = '{busy: busy_ff, done: done_ff, sat: done_ff && !fits};
   end

endmodule

// ===== design/lorenz_euler_step_unit.sv =====
// Lorenz system stepper: each accepted item advances the held point (x, y, z) one
// forward-Euler step, v = (a(y-x), x(b-z)-y, xy-cz), p += v*dt, and returns the new
// point plus an overflow flag. The first item after reset, or an item with restart
// set, first reloads the point from the start registers. Values are signed Q8.24;
// every product is truncated toward minus infinity and then saturated, every sum
// and difference is saturated, and overflow reports any saturation in the step.
// All seven products of a step run one after another on one bit-serial multiplier
// that retires one multiplier bit per cycle; the adds, subtracts and output load
// are sequencer states of their own. One item is in work at a time; req_stall is
// high from accept until the result is loaded into the output register, and a
// result waiting there does not hold off the next item. Registers are written
// through csr_write/csr_index/csr_data; the user must write them while idle only,
// as the block itself does not enforce it.
module lorenz_euler_step_unit (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  csr_write,
   input  lz_pkg::csr_index_type                 csr_index,
   input  logic [lz_pkg::CSR_BITS-1:0]           csr_data,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_restart,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [lz_pkg::OUT_BITS-1:0]    rsp_pos_x,
   output logic signed [lz_pkg::OUT_BITS-1:0]    rsp_pos_y,
   output logic signed [lz_pkg::OUT_BITS-1:0]    rsp_pos_z,
   output logic                                  rsp_overflow
);
   import lz_pkg::*;

   // Configuration registers
   logic [CSR_BITS-1:0]         sigma_ff, rho_ff, beta_ff;
   logic [DT_BITS-1:0]          dt_ff;
   logic [CSR_BITS-1:0]         start_x_ff, start_y_ff, start_z_ff;

   // Sequencer and datapath
   lz_state_type                state_ff, state_in;
   logic                        started_ff, started_in;
   logic                        issued_ff, issued_in;
   logic                        ovf_ff, ovf_in;
   word_type                    x_ff, x_in, y_ff, y_in, z_ff, z_in;
   word_type                    vx_ff, vx_in, vy_ff, vy_in;
   word_type                    t1_ff, t1_in, t2_ff, t2_in;

   // Output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_BITS-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   logic                        accept;
   logic                        out_free;
   logic                        is_mul;
   logic                        mul_start;
   logic                        mul_take;
   word_type                    alu_a, alu_b;
   logic                        alu_sub;
   alu_result_type              alu_res;
   opnd_type                    mul_a, mul_b;
   opnd_type                    dt_opnd;
   mul_status_type              mul_stat;
   word_type                    mul_product;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff   <= SIGMA_RESET;
         rho_ff     <= RHO_RESET;
         beta_ff    <= BETA_RESET;
         dt_ff      <= DT_RESET;
         start_x_ff <= START_RESET;
         start_y_ff <= START_RESET;
         start_z_ff <= START_RESET;
      end else if (csr_write) begin
         if (csr_index == REG_SIGMA)   sigma_ff   <= csr_data;
         if (csr_index == REG_RHO)     rho_ff     <= csr_data;
         if (csr_index == REG_BETA)    beta_ff    <= csr_data;
         if (csr_index == REG_DT)      dt_ff      <= csr_data[DT_BITS-1:0];
         if (csr_index == REG_START_X) start_x_ff <= csr_data;
         if (csr_index == REG_START_Y) start_y_ff <= csr_data;
         if (csr_index == REG_START_Z) start_z_ff <= csr_data;
      end
   end

   // ---------------- shared multiplier ----------------
   lz_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .status  (mul_stat),
      .product (mul_product)
   );

   assign dt_opnd   = OPND_BITS'(dt_ff);   // unsigned dt, zero-extended
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign mul_start = is_mul && !issued_ff;
   assign mul_take  = is_mul && issued_ff && mul_stat.done;

   // Operand routing for the adder and the multiplier, per step of the sequence
   always_comb begin
      alu_a   = y_ff;
      alu_b   = x_ff;
      alu_sub = 1'b1;
      mul_a   = opnd_type'(x_ff);
      mul_b   = opnd_type'(y_ff);
      is_mul  = 1'b0;
      unique case (state_ff)
         ST_SUB_YX: begin alu_a = y_ff;             alu_b = x_ff;  end
         ST_SUB_BZ: begin alu_a = to_word(rho_ff);  alu_b = z_ff;  end
         ST_SUB_VY: begin alu_a = t1_ff;            alu_b = y_ff;  end
         ST_SUB_VZ: begin alu_a = t1_ff;            alu_b = t2_ff; end
         ST_ADD_X:  begin alu_a = x_ff; alu_b = t2_ff; alu_sub = 1'b0; end
         ST_ADD_Y:  begin alu_a = y_ff; alu_b = t2_ff; alu_sub = 1'b0; end
         ST_ADD_Z:  begin alu_a = z_ff; alu_b = t2_ff; alu_sub = 1'b0; end
         ST_MUL_VX: begin
            is_mul = 1'b1;
            mul_a  = opnd_type'(to_word(sigma_ff));
            mul_b  = opnd_type'(vx_ff);
         end
         ST_MUL_XB: begin
            is_mul = 1'b1;
            mul_a  = opnd_type'(x_ff);
            mul_b  = opnd_type'(t1_ff);
         end
         ST_MUL_XY: begin
            is_mul = 1'b1;
            mul_a  = opnd_type'(x_ff);
            mul_b  = opnd_type'(y_ff);
         end
         ST_MUL_CZ: begin
            is_mul = 1'b1;
            mul_a  = opnd_type'(to_word(beta_ff));
            mul_b  = opnd_type'(z_ff);
         end
         ST_MUL_DX: begin
            is_mul = 1'b1;
            mul_a  = opnd_type'(vx_ff);
            mul_b  = dt_opnd;
         end
         ST_MUL_DY: begin
            is_mul = 1'b1;
            mul_a  = opnd_type'(vy_ff);
            mul_b  = dt_opnd;
         end
         ST_MUL_DZ: begin
            is_mul = 1'b1;
            mul_a  = opnd_type'(t1_ff);
            mul_b  = dt_opnd;
         end
         ST_IDLE, ST_OUT: begin
         end
         default: begin
         end
      endcase
   end

   assign alu_res = add_sub_sat(alu_a, alu_b, alu_sub);

   // Sequencer: next state and datapath register loads
   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      ovf_in       = ovf_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // a multiply state issues once, then waits for the product
      issued_in = issued_ff;
      if (mul_start) issued_in = 1'b1;
      if (mul_take)  issued_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               started_in = 1'b1;
               ovf_in     = 1'b0;
               if (req_restart || !started_ff) begin
                  x_in = to_word(start_x_ff);
                  y_in = to_word(start_y_ff);
                  z_in = to_word(start_z_ff);
               end
               state_in = ST_SUB_YX;
            end
         end
         ST_SUB_YX: begin
            vx_in    = alu_res.value;              // y - x, scaled by a next
            ovf_in   = ovf_ff | alu_res.sat;
            state_in = ST_MUL_VX;
         end
         ST_MUL_VX: begin
            if (mul_take) begin
               vx_in    = mul_product;
               ovf_in   = ovf_ff | mul_stat.sat;
               state_in = ST_SUB_BZ;
            end
         end
         ST_SUB_BZ: begin
            t1_in    = alu_res.value;
            ovf_in   = ovf_ff | alu_res.sat;
            state_in = ST_MUL_XB;
         end
         ST_MUL_XB: begin
            if (mul_take) begin
               t1_in    = mul_product;
               ovf_in   = ovf_ff | mul_stat.sat;
               state_in = ST_SUB_VY;
            end
         end
         ST_SUB_VY: begin
            vy_in    = alu_res.value;
            ovf_in   = ovf_ff | alu_res.sat;
            state_in = ST_MUL_XY;
         end
         ST_MUL_XY: begin
            if (mul_take) begin
               t1_in    = mul_product;
               ovf_in   = ovf_ff | mul_stat.sat;
               state_in = ST_MUL_CZ;
            end
         end
         ST_MUL_CZ: begin
            if (mul_take) begin
               t2_in    = mul_product;
               ovf_in   = ovf_ff | mul_stat.sat;
               state_in = ST_SUB_VZ;
            end
         end
         ST_SUB_VZ: begin
            t1_in    = alu_res.value;              // vz lives in t1 from here on
            ovf_in   = ovf_ff | alu_res.sat;
            state_in = ST_MUL_DX;
         end
         ST_MUL_DX: begin
            if (mul_take) begin
               t2_in    = mul_product;
               ovf_in   = ovf_ff | mul_stat.sat;
               state_in = ST_ADD_X;
            end
         end
         ST_ADD_X: begin
            x_in     = alu_res.value;
            ovf_in   = ovf_ff | alu_res.sat;
            state_in = ST_MUL_DY;
         end
         ST_MUL_DY: begin
            if (mul_take) begin
               t2_in    = mul_product;
               ovf_in   = ovf_ff | mul_stat.sat;
               state_in = ST_ADD_Y;
            end
         end
         ST_ADD_Y: begin
            y_in     = alu_res.value;
            ovf_in   = ovf_ff | alu_res.sat;
            state_in = ST_MUL_DZ;
         end
         ST_MUL_DZ: begin
            if (mul_take) begin
               t2_in    = mul_product;
               ovf_in   = ovf_ff | mul_stat.sat;
               state_in = ST_ADD_Z;
            end
         end
         ST_ADD_Z: begin
            z_in     = alu_res.value;
            ovf_in   = ovf_ff | alu_res.sat;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold here while the previous item still sits in the output register
            if (out_free) begin
               rsp_x_in     = OUT_BITS'(x_ff);
               rsp_y_in     = OUT_BITS'(y_ff);
               rsp_z_in     = OUT_BITS'(z_ff);
               rsp_ovf_in   = ovf_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
      end
      ovf_ff     <= ovf_in;
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      t1_ff      <= t1_in;
      t2_ff      <= t2_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pos_x    = rsp_x_ff;
   assign rsp_pos_y    = rsp_y_ff;
   assign rsp_pos_z    = rsp_z_ff;
   assign rsp_overflow = rsp_ovf_ff;

   // ---------------- assertions ----------------
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SUB_YX) && started_ff)
      else $error("accepted item did not start the step");

   a_mul_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_stat.busy && !mul_stat.done)
      else $error("multiplier started while still in use");

   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> is_mul && issued_ff)
      else $error("product returned outside a multiply step");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished step not loaded into the output register");

   a_no_lost_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !out_free) |=> (state_ff == ST_OUT) && rsp_valid_ff)
      else $error("finished step left while the output register was full");

endmodule

// ===== tb/lorenz_step_checker.sv =====
`timescale 1ns / 1ps

module lorenz_step_checker (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               csr_write,
   input  lz_pkg::csr_index_type              csr_index,
   input  logic [lz_pkg::CSR_BITS-1:0]        csr_data,

   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_restart,

   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [lz_pkg::OUT_BITS-1:0] rsp_pos_x,
   input  logic signed [lz_pkg::OUT_BITS-1:0] rsp_pos_y,
   input  logic signed [lz_pkg::OUT_BITS-1:0] rsp_pos_z,
   input  logic                               rsp_overflow,

   output int                                 error_count,
   output int                                 pending_count
);
   import lz_pkg::*;

   typedef logic signed [127:0] wide_type;

   localparam wide_type WORD_MAX = (wide_type'(1) <<< (WORD_BITS - 1)) - 1;
   localparam wide_type WORD_MIN = -(wide_type'(1) <<< (WORD_BITS - 1));

   typedef struct {
      logic [OUT_BITS-1:0] x;
      logic [OUT_BITS-1:0] y;
      logic [OUT_BITS-1:0] z;
      logic                ovf;
   } point_type;

   point_type expected_points[$];

   // shadow registers and held point
   logic [CSR_BITS-1:0] sigma_reg, rho_reg, beta_reg;
   logic [CSR_BITS-1:0] sx_reg, sy_reg, sz_reg;
   logic [DT_BITS-1:0]  dt_reg;
   word_type            pos_x, pos_y, pos_z;
   logic                loaded;
   logic                clipped;

   function automatic word_type clip(input wide_type v);
      if (v > WORD_MAX) begin
         clipped = 1'b1;
         return word_type'(WORD_MAX);
      end
      if (v < WORD_MIN) begin
         clipped = 1'b1;
         return word_type'(WORD_MIN);
      end
      return word_type'(v);
   endfunction

   function automatic word_type sum_sat(input word_type a, input word_type b);
      return clip(wide_type'(a) + wide_type'(b));
   endfunction

   function automatic word_type diff_sat(input word_type a, input word_type b);
      return clip(wide_type'(a) - wide_type'(b));
   endfunction

   // exact product, floor shift, then clip; dt arrives zero-extended
   function automatic word_type prod_sat(input wide_type a, input wide_type b);
      return clip((a * b) >>> FRAC_BITS);
   endfunction

   function automatic point_type advance_point(input logic restart);
      word_type  a, b, c, x, y, z, vx, vy, vz;
      point_type r;
      a = word_type'($signed(sigma_reg));
      b = word_type'($signed(rho_reg));
      c = word_type'($signed(beta_reg));
      if (restart || !loaded) begin
         pos_x  = word_type'($signed(sx_reg));
         pos_y  = word_type'($signed(sy_reg));
         pos_z  = word_type'($signed(sz_reg));
         loaded = 1'b1;
      end
      x = pos_x;
      y = pos_y;
      z = pos_z;
      clipped = 1'b0;
      vx = prod_sat(a, diff_sat(y, x));
      vy = diff_sat(prod_sat(x, diff_sat(b, z)), y);
      vz = diff_sat(prod_sat(x, y), prod_sat(c, z));
      pos_x = sum_sat(x, prod_sat(vx, dt_reg));
      pos_y = sum_sat(y, prod_sat(vy, dt_reg));
      pos_z = sum_sat(z, prod_sat(vz, dt_reg));
      r.x   = OUT_BITS'(pos_x);
      r.y   = OUT_BITS'(pos_y);
      r.z   = OUT_BITS'(pos_z);
      r.ovf = clipped;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [OUT_BITS-1:0] want,
                                       input logic [OUT_BITS-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         sigma_reg   = SIGMA_RESET;
         rho_reg     = RHO_RESET;
         beta_reg    = BETA_RESET;
         dt_reg      = DT_RESET;
         sx_reg      = START_RESET;
         sy_reg      = START_RESET;
         sz_reg      = START_RESET;
         pos_x       = '0;
         pos_y       = '0;
         pos_z       = '0;
         loaded      = 1'b0;
         error_count = 0;
         expected_points.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_SIGMA:   sigma_reg = csr_data;
               REG_RHO:     rho_reg   = csr_data;
               REG_BETA:    beta_reg  = csr_data;
               REG_DT:      dt_reg    = csr_data[DT_BITS-1:0];
               REG_START_X: sx_reg    = csr_data;
               REG_START_Y: sy_reg    = csr_data;
               REG_START_Z: sz_reg    = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               error_count++;
               $display("%0t: unexpected item, expected none, got %h %h %h %b", $time,
                        rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_overflow);
            end else begin
               want = expected_points.pop_front();
               check_field("pos_x", want.x, rsp_pos_x);
               check_field("pos_y", want.y, rsp_pos_y);
               check_field("pos_z", want.z, rsp_pos_z);
               check_field("overflow", OUT_BITS'(want.ovf), OUT_BITS'(rsp_overflow));
            end
         end
         if (req_valid && !req_stall)
            expected_points.push_back(advance_point(req_restart));
      end
      pending_count = expected_points.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import lz_pkg::*;

   // unmapped register index: writes there must leave every register alone
   localparam csr_index_type REG_NONE = 3'd7;

   localparam int RANDOM_PHASES = 13;
   localparam int PHASE_ITEMS   = 110;
   // accept-to-result time of one step at the default word size
   localparam int STEP_LATENCY  = 246;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       csr_write   = 1'b0;
   csr_index_type              csr_index   = REG_SIGMA;
   logic [CSR_BITS-1:0]        csr_data    = '0;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   logic                       req_restart = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   logic signed [OUT_BITS-1:0] rsp_pos_x;
   logic signed [OUT_BITS-1:0] rsp_pos_y;
   logic signed [OUT_BITS-1:0] rsp_pos_z;
   logic                       rsp_overflow;

   int   fail_count;
   int   pending_count;

   // calm: no idling on either side; hold_request: cycles the receiver is to hold off
   logic calm         = 1'b0;
   int   hold_request = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   lorenz_euler_step_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_restart  (req_restart),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_pos_x    (rsp_pos_x),
      .rsp_pos_y    (rsp_pos_y),
      .rsp_pos_z    (rsp_pos_z),
      .rsp_overflow (rsp_overflow)
   );

   lorenz_step_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_pos_z     (rsp_pos_z),
      .rsp_overflow  (rsp_overflow),
      .error_count   (fail_count),
      .pending_count (pending_count)
   );

   // one register write; the enable drops on the next falling edge
   task automatic write_reg(input csr_index_type idx, input logic [CSR_BITS-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Offer one tick item and return at the edge that takes it. Valid stays high
   // afterwards, so the next call either changes the payload or lowers valid at
   // the coming falling edge - never both.
   task automatic send_tick(input logic restart);
      int gap;
      gap = 0;
      // gaps up to a bit over one step, so valid rises at every phase of the work
      if (!calm && $urandom_range(0, 99) < 20)
         gap = $urandom_range(1, 300);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and wait for every outstanding result; the checker updates
   // its count at the rising edge, so it is read at the falling one
   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // random Q8.24 value in +-span
   function automatic logic [CSR_BITS-1:0] coord(input int span);
      int v;
      v = int'($urandom_range(0, (2 * span) << 24)) - (span << 24);
      return v;
   endfunction

   // integer part in [lo, hi], random fraction
   function automatic logic [CSR_BITS-1:0] coef(input int lo, input int hi);
      return (int'($urandom_range(lo, hi)) << 24) | $urandom_range(0, 24'hFFFFFF);
   endfunction

   function automatic logic [CSR_BITS-1:0] edge_word();
      case ($urandom_range(0, 4))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CSR_BITS-1:0] edge_dt();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 32'h00FF_FFFF;
         2:       return 1;
         default: return $urandom_range(0, 24'hFFFFFF);
      endcase
   endfunction

   // register setting for one random phase
   task automatic config_phase(input int kind);
      case (kind)
         0: begin
            // near the classic attractor: trajectories stay bounded and wander
            write_reg(REG_SIGMA, coef(8, 14));
            write_reg(REG_RHO, coef(20, 40));
            write_reg(REG_BETA, coef(1, 4));
            write_reg(REG_DT, $urandom_range(2000, 200000));
            write_reg(REG_START_X, coord(20));
            write_reg(REG_START_Y, coord(20));
            write_reg(REG_START_Z, coord(40));
         end
         1: begin
            // anything goes, upper bits of the time step included
            write_reg(REG_SIGMA, $urandom);
            write_reg(REG_RHO, $urandom);
            write_reg(REG_BETA, $urandom);
            write_reg(REG_DT, $urandom);
            write_reg(REG_START_X, $urandom);
            write_reg(REG_START_Y, $urandom);
            write_reg(REG_START_Z, $urandom);
         end
         2: begin
            write_reg(REG_SIGMA, edge_word());
            write_reg(REG_RHO, edge_word());
            write_reg(REG_BETA, edge_word());
            write_reg(REG_DT, edge_dt());
            write_reg(REG_START_X, edge_word());
            write_reg(REG_START_Y, edge_word());
            write_reg(REG_START_Z, edge_word());
         end
         default: begin
            // touch a random subset of all indices, the unmapped one among the candidates
            for (int i = 0; i <= REG_NONE; i++)
               if ($urandom_range(0, 1))
                  write_reg(csr_index_type'(i), $urandom);
         end
      endcase
   endtask

   // receiver: random stalls, or a counted hold-off when asked for one
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 20);
         end
      end
   end

   // stimulus and verdict
   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // reset setting: the first tick loads the start point even without restart
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_drain();

      // write to the unmapped index is dropped, the trajectory just goes on
      write_reg(REG_NONE, $urandom);
      send_tick(1'b0);
      wait_drain();

      // zero time step: the point stays where it is
      write_reg(REG_DT, '0);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_drain();

      // extremes one way: saturation all over
      write_reg(REG_SIGMA, 32'h7FFF_FFFF);
      write_reg(REG_RHO, 32'h8000_0000);
      write_reg(REG_BETA, 32'h7FFF_FFFF);
      write_reg(REG_DT, 32'h00FF_FFFF);
      write_reg(REG_START_X, 32'h7FFF_FFFF);
      write_reg(REG_START_Y, 32'h8000_0000);
      write_reg(REG_START_Z, 32'h7FFF_FFFF);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_drain();

      // and the other way
      write_reg(REG_SIGMA, 32'h8000_0000);
      write_reg(REG_RHO, 32'h7FFF_FFFF);
      write_reg(REG_BETA, 32'h8000_0000);
      write_reg(REG_START_X, 32'h8000_0000);
      write_reg(REG_START_Y, 32'h7FFF_FFFF);
      write_reg(REG_START_Z, 32'h8000_0000);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_drain();

      // reset-value coefficients from the origin, a fixed point of the system
      write_reg(REG_SIGMA, SIGMA_RESET);
      write_reg(REG_RHO, RHO_RESET);
      write_reg(REG_BETA, BETA_RESET);
      write_reg(REG_DT, CSR_BITS'(DT_RESET));
      write_reg(REG_START_X, '0);
      write_reg(REG_START_Y, '0);
      write_reg(REG_START_Z, '0);
      send_tick(1'b1);
      send_tick(1'b0);

      // random phases: first one of each kind, then mixed
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drain();
         config_phase(p < 4 ? p : $urandom_range(0, 3));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_tick($urandom_range(0, 99) < 5);
            // flags change right after a rising edge, away from the receiver's sampling
            if (n == 0)
               calm = (p == 3);
            // long hold-off: output register fills, then the block stalls its input
            if (p == 5 && n == 40)
               hold_request = 1500;
            // sender pause mid-trajectory until everything is back
            if (p == 7 && n == 50)
               wait_drain();
         end
      end

      wait_drain();
      repeat (STEP_LATENCY + 20) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("[lorenz_euler_step_unit] OK");
      else
         $display("[lorenz_euler_step_unit] ERROR");
      $finish;
   end

   // watchdog: several times the slowest legal run
   initial begin
      #50_000_000;
      $display("[lorenz_euler_step_unit] ERROR");
      $finish;
   end

endmodule
